[hdl/sipd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipd_pkg
// Shared widths and prefix tree node codes for the signed integer prefix
// decoder.
// ----------------------------------------------------------------------------
package sipd_pkg;

   localparam int VALUE_W = 16;   // decoded value, two's complement
   localparam int MAG_W   = 15;   // magnitude before sign handling
   localparam int ACC_W   = 14;   // suffix accumulator
   localparam int CLASS_W = 4;    // class index and suffix count

   // Prefix tree nodes. NODE_EXTRA gathers the low class bits.
   typedef enum logic [2:0] {
      NODE_ROOT  = 3'd0,
      NODE_0     = 3'd1,
      NODE_1     = 3'd2,
      NODE_01    = 3'd3,
      NODE_11    = 3'd4,
      NODE_111   = 3'd5,
      NODE_1111  = 3'd6,
      NODE_EXTRA = 3'd7
   } node_type;

   // Class base values of the prefix tree and the class of prefix 11110
   localparam logic [CLASS_W-1:0] CLASS_BASE_10    = 4'd3;
   localparam logic [CLASS_W-1:0] CLASS_BASE_110   = 4'd7;
   localparam logic [CLASS_W-1:0] CLASS_BASE_1110  = 4'd11;
   localparam logic [CLASS_W-1:0] CLASS_13         = 4'd13;
   localparam logic [CLASS_W-1:0] CLASS_BASE_11111 = 4'd14;

endpackage

[hdl/signed_int_prefix_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_prefix_decoder
// Bit-serial decoder for a static prefix code of integers. Optional sign bit,
// prefix tree giving a class k, then k-1 suffix bits if k >= 2, MSB first.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  req_code_bit (1)
//  rsp       out        rsp_valid / rsp_stall  rsp_decoded_value (16, signed)
//  csr       in         csr_write_enable       csr_write_data (signed_mode)
//
//  One code bit per cycle while req_stall is low; the decoder state is updated
//  in the cycle the bit is accepted, and a finished value goes into the output
//  register, or into the skid entry if the output is held. A two-entry output
//  (register plus skid) lets bits keep flowing while a result waits; req_stall
//  rises only when both entries are full. Synchronous reset clears the decoder
//  to the start of a codeword, empties the output and sets signed_mode to 1.
// ----------------------------------------------------------------------------
module signed_int_prefix_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_code_bit,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [sipd_pkg::VALUE_W-1:0]  rsp_decoded_value,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_write_data
);

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_PREFIX = 2'd1,
      PH_SUFFIX = 2'd2
   } phase_type;

   localparam int VW = sipd_pkg::VALUE_W;
   localparam int MW = sipd_pkg::MAG_W;
   localparam int AW = sipd_pkg::ACC_W;
   localparam int CW = sipd_pkg::CLASS_W;

   phase_type          phase_ff, phase_in;
   sipd_pkg::node_type node_ff, node_in;
   logic [CW-1:0]      class_ff, class_in;
   logic [CW-1:0]      left_ff, left_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               signed_mode_ff;

   logic               out_valid_ff, skid_valid_ff;
   logic [VW-1:0]      out_value_ff, skid_value_ff;

   logic               accept, hit;
   logic [VW-1:0]      hit_value;

   // prefix walk inputs and class_done hand-off
   sipd_pkg::node_type pre_node;
   logic [CW-1:0]      pre_class, pre_left, left_dec, cls_sum;
   logic               pre_neg, run_prefix, cd_go;
   logic [CW-1:0]      cd_k;
   logic [MW-1:0]      mag;
   logic [AW-1:0]      acc_shift;
   logic               neg_use;

   assign accept = req_valid & ~req_stall;

   always_comb begin
      phase_in   = phase_ff;
      node_in    = node_ff;
      class_in   = class_ff;
      left_in    = left_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      hit        = 1'b0;
      mag        = '0;
      neg_use    = neg_ff;
      run_prefix = 1'b0;
      pre_node   = node_ff;
      pre_class  = class_ff;
      pre_left   = left_ff;
      pre_neg    = neg_ff;
      cd_go      = 1'b0;
      cd_k       = '0;
      left_dec   = '0;
      cls_sum    = '0;
      acc_shift  = {acc_ff[AW-2:0], req_code_bit};

      if (accept) begin
         case (phase_ff)
            PH_SUFFIX: begin
               acc_in  = acc_shift;
               left_in = (left_ff != '0) ? left_ff - CW'(1) : left_ff;
               if (left_in == '0) begin
                  hit = 1'b1;
                  if (class_ff != '0) begin
                     mag = (MW'(1) << (class_ff - CW'(1))) + MW'(acc_shift);
                  end else begin
                     mag = MW'(acc_shift);
                  end
               end
            end
            PH_PREFIX: begin
               run_prefix = 1'b1;
            end
            default: begin
               // start of a codeword
               node_in  = sipd_pkg::NODE_ROOT;
               class_in = '0;
               left_in  = '0;
               acc_in   = '0;
               neg_in   = 1'b0;
               if (signed_mode_ff) begin
                  neg_in   = req_code_bit;
                  phase_in = PH_PREFIX;
               end else begin
                  run_prefix = 1'b1;
                  pre_node   = sipd_pkg::NODE_ROOT;
                  pre_class  = '0;
                  pre_left   = '0;
                  pre_neg    = 1'b0;
               end
            end
         endcase
      end

      if (run_prefix) begin
         phase_in = PH_PREFIX;
         neg_use  = pre_neg;
         case (pre_node)
            sipd_pkg::NODE_ROOT: begin
               node_in = req_code_bit ? sipd_pkg::NODE_1 : sipd_pkg::NODE_0;
            end
            sipd_pkg::NODE_0: begin
               if (!req_code_bit) begin
                  cd_go = 1'b1;
                  cd_k  = '0;
               end else begin
                  node_in = sipd_pkg::NODE_01;
               end
            end
            sipd_pkg::NODE_01: begin
               cd_go = 1'b1;
               cd_k  = CW'(1) + CW'(req_code_bit);
            end
            sipd_pkg::NODE_1: begin
               if (!req_code_bit) begin
                  node_in  = sipd_pkg::NODE_EXTRA;
                  class_in = sipd_pkg::CLASS_BASE_10;
                  left_in  = CW'(2);
               end else begin
                  node_in = sipd_pkg::NODE_11;
               end
            end
            sipd_pkg::NODE_11: begin
               if (!req_code_bit) begin
                  node_in  = sipd_pkg::NODE_EXTRA;
                  class_in = sipd_pkg::CLASS_BASE_110;
                  left_in  = CW'(2);
               end else begin
                  node_in = sipd_pkg::NODE_111;
               end
            end
            sipd_pkg::NODE_111: begin
               if (!req_code_bit) begin
                  node_in  = sipd_pkg::NODE_EXTRA;
                  class_in = sipd_pkg::CLASS_BASE_1110;
                  left_in  = CW'(1);
               end else begin
                  node_in = sipd_pkg::NODE_1111;
               end
            end
            sipd_pkg::NODE_1111: begin
               if (!req_code_bit) begin
                  cd_go = 1'b1;
                  cd_k  = sipd_pkg::CLASS_13;
               end else begin
                  node_in  = sipd_pkg::NODE_EXTRA;
                  class_in = sipd_pkg::CLASS_BASE_11111;
                  left_in  = CW'(1);
               end
            end
            default: begin
               // low class bits, MSB first, added onto the base
               if (pre_left == '0) begin
                  cd_go = 1'b1;
                  cd_k  = pre_class;
               end else begin
                  left_dec = pre_left - CW'(1);
                  cls_sum  = pre_class + (CW'(req_code_bit) << left_dec);
                  left_in  = left_dec;
                  class_in = cls_sum;
                  if (left_dec == '0) begin
                     cd_go = 1'b1;
                     cd_k  = cls_sum;
                  end
               end
            end
         endcase

         if (cd_go) begin
            class_in = cd_k;
            if (cd_k <= CW'(1)) begin
               hit = 1'b1;
               mag = MW'(cd_k);
            end else begin
               phase_in = PH_SUFFIX;
               left_in  = cd_k - CW'(1);
               acc_in   = '0;
            end
         end
      end

      if (hit) begin
         // codeword done: back to the start state
         phase_in = PH_START;
         node_in  = sipd_pkg::NODE_ROOT;
         class_in = '0;
         left_in  = '0;
         acc_in   = '0;
         neg_in   = 1'b0;
      end
   end

   assign hit_value = neg_use ? ~{1'b0, mag} : {1'b0, mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         node_ff        <= sipd_pkg::NODE_ROOT;
         class_ff       <= '0;
         left_ff        <= '0;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         signed_mode_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         node_ff  <= node_in;
         class_ff <= class_in;
         left_ff  <= left_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         if (csr_write_enable) begin
            signed_mode_ff <= csr_write_data;
         end
      end
   end

   // output register with a skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= hit;
         end else begin
            out_valid_ff  <= hit;
            skid_valid_ff <= 1'b0;
         end
      end else if (hit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         out_value_ff  <= skid_valid_ff ? skid_value_ff : hit_value;
         skid_value_ff <= hit_value;
      end else if (hit) begin
         skid_value_ff <= hit_value;
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_decoded_value = out_value_ff;

endmodule

[hdl/sipd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipd_checker
// Port-level checks of the signed integer prefix decoder, bound to the top.
// ----------------------------------------------------------------------------
module sipd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [sipd_pkg::VALUE_W-1:0] rsp_decoded_value
);

   // a held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_decoded_value))
      else $error("stalled result changed");

   // reset empties the output side and releases the input
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // no result appears without a request or a queued result
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !req_stall && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("result without request");

   // input stalls only after the output was held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without held result");

endmodule

bind signed_int_prefix_decoder sipd_checker u_sipd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_decoded_value (rsp_decoded_value)
);

[dv/signed_int_prefix_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_prefix_decoder_test
// Self-checking bench for the bit-serial integer prefix decoder. Code bit
// requests come from a queue that the stimulus block fills with codewords
// of random class, sign and suffix, plus stray bits. A bit-level predictor
// follows every accepted request and queues the value it expects; each
// decoded value that leaves the block is checked against the oldest one.
// Both sides idle in random bursts; signed_mode is changed between phases.
// ----------------------------------------------------------------------------
module signed_int_prefix_decoder_test;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_BITS   = 110;

   typedef enum logic [1:0] {
      AT_START  = 2'd0,
      IN_PREFIX = 2'd1,
      IN_SUFFIX = 2'd2
   } word_phase_type;

   logic                                 clock            = 1'b0;
   logic                                 reset            = 1'b1;
   logic                                 req_valid        = 1'b0;
   logic                                 req_stall;
   logic                                 req_code_bit     = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall        = 1'b0;
   logic signed [sipd_pkg::VALUE_W-1:0]  rsp_decoded_value;
   logic                                 csr_write_enable = 1'b0;
   logic                                 csr_write_data   = 1'b0;

   bit                                   code_bits[$];
   logic signed [sipd_pkg::VALUE_W-1:0]  expected_values[$];
   int                                   idle_pct    = 0;
   int                                   send_gap    = 0;
   int                                   stall_left  = 0;
   int                                   cycles      = 0;
   int                                   errors      = 0;
   int                                   queued_bits = 0;
   bit                                   stim_signed = 1'b1;

   // decoder copy
   logic                                 mode_signed;
   word_phase_type                       dec_phase;
   sipd_pkg::node_type                   dec_node;
   logic [sipd_pkg::CLASS_W-1:0]         dec_class;
   logic [sipd_pkg::CLASS_W-1:0]         dec_left;
   logic [sipd_pkg::ACC_W-1:0]           dec_acc;
   logic                                 dec_neg;

   signed_int_prefix_decoder DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_code_bit      (req_code_bit),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_decoded_value (rsp_decoded_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic void restart_word();
      dec_phase = AT_START;
      dec_node  = sipd_pkg::NODE_ROOT;
      dec_class = '0;
      dec_left  = '0;
      dec_acc   = '0;
      dec_neg   = 1'b0;
   endfunction

   function automatic void finish_word(input logic [sipd_pkg::MAG_W-1:0] mag,
                                       output logic signed [sipd_pkg::VALUE_W-1:0] val);
      val = dec_neg ? ~{1'b0, mag} : {1'b0, mag};
      restart_word();
   endfunction

   function automatic bit close_class(input logic [sipd_pkg::CLASS_W-1:0] k,
                                      output logic signed [sipd_pkg::VALUE_W-1:0] val);
      dec_class = k;
      if (k <= 4'd1) begin
         finish_word({11'd0, k}, val);
         return 1'b1;
      end
      dec_phase = IN_SUFFIX;
      dec_left  = k - 4'd1;
      dec_acc   = '0;
      return 1'b0;
   endfunction

   function automatic void gather(input logic [sipd_pkg::CLASS_W-1:0] base,
                                  input logic [sipd_pkg::CLASS_W-1:0] n);
      dec_node  = sipd_pkg::NODE_EXTRA;
      dec_class = base;
      dec_left  = n;
   endfunction

   function automatic bit tree_step(input logic b,
                                    output logic signed [sipd_pkg::VALUE_W-1:0] val);
      dec_phase = IN_PREFIX;
      case (dec_node)
         sipd_pkg::NODE_ROOT: dec_node = b ? sipd_pkg::NODE_1 : sipd_pkg::NODE_0;
         sipd_pkg::NODE_0: begin
            if (!b) return close_class(4'd0, val);
            dec_node = sipd_pkg::NODE_01;
         end
         sipd_pkg::NODE_01: return close_class(b ? 4'd2 : 4'd1, val);
         sipd_pkg::NODE_1: begin
            if (!b) gather(sipd_pkg::CLASS_BASE_10, 4'd2);
            else dec_node = sipd_pkg::NODE_11;
         end
         sipd_pkg::NODE_11: begin
            if (!b) gather(sipd_pkg::CLASS_BASE_110, 4'd2);
            else dec_node = sipd_pkg::NODE_111;
         end
         sipd_pkg::NODE_111: begin
            if (!b) gather(sipd_pkg::CLASS_BASE_1110, 4'd1);
            else dec_node = sipd_pkg::NODE_1111;
         end
         sipd_pkg::NODE_1111: begin
            if (!b) return close_class(sipd_pkg::CLASS_13, val);
            gather(sipd_pkg::CLASS_BASE_11111, 4'd1);
         end
         default: begin
            if (dec_left == 4'd0) return close_class(dec_class, val);
            dec_left  = dec_left - 4'd1;
            dec_class = dec_class + ({3'd0, b} << dec_left);
            if (dec_left == 4'd0) return close_class(dec_class, val);
         end
      endcase
      return 1'b0;
   endfunction

   // One accepted code bit; returns 1 when a codeword completes.
   function automatic bit decode_bit(input logic b,
                                     output logic signed [sipd_pkg::VALUE_W-1:0] val);
      logic [sipd_pkg::MAG_W-1:0] mag;
      if (dec_phase == IN_SUFFIX) begin
         dec_acc = {dec_acc[sipd_pkg::ACC_W-2:0], b};
         if (dec_left != 4'd0) dec_left = dec_left - 4'd1;
         if (dec_left == 4'd0) begin
            if (dec_class >= 4'd1)
               mag = (15'd1 << (dec_class - 4'd1)) + {1'b0, dec_acc};
            else
               mag = {1'b0, dec_acc};
            finish_word(mag, val);
            return 1'b1;
         end
         return 1'b0;
      end
      if (dec_phase == IN_PREFIX) return tree_step(b, val);
      // start of a codeword; the sign is read only here
      restart_word();
      if (mode_signed) begin
         dec_neg   = b;
         dec_phase = IN_PREFIX;
         return 1'b0;
      end
      return tree_step(b, val);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_code_bit <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (code_bits.size() != 0) begin
            if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
               send_gap = $urandom_range(8, 0);
               req_valid <= 1'b0;
            end else begin
               req_valid    <= 1'b1;
               req_code_bit <= code_bits.pop_front();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         stall_left = $urandom_range(8, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: check outgoing values first, then predict from the request
   always @(posedge clock) begin : monitor
      logic signed [sipd_pkg::VALUE_W-1:0] val;
      logic signed [sipd_pkg::VALUE_W-1:0] want;
      if (reset) begin
         mode_signed = 1'b1;
         restart_word();
         expected_values.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               $error("decoded_value: expected none, got %0d", rsp_decoded_value);
               errors++;
            end else begin
               want = expected_values.pop_front();
               if (rsp_decoded_value !== want) begin
                  $error("decoded_value: expected %0d, got %0d", want, rsp_decoded_value);
                  errors++;
               end
            end
         end
         if (csr_write_enable) mode_signed = csr_write_data;
         if (req_valid && !req_stall) begin
            if (decode_bit(req_code_bit, val)) expected_values.push_back(val);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_bits(input int unsigned value, input int count);
      for (int i = count - 1; i >= 0; i--) begin
         code_bits.push_back(value[i]);
         queued_bits++;
      end
   endtask

   // Codeword of class k; the sign bit goes out only in signed mode.
   task automatic queue_word(input bit neg, input int k, input int unsigned suffix);
      if (stim_signed) push_bits(neg, 1);
      if (k == 0) push_bits('b00, 2);
      else if (k <= 2) push_bits(k == 1 ? 'b010 : 'b011, 3);
      else if (k <= 6) push_bits(('b10 << 2) | (k - 3), 4);
      else if (k <= 10) push_bits(('b110 << 2) | (k - 7), 5);
      else if (k <= 12) push_bits(('b1110 << 1) | (k - 11), 5);
      else if (k == 13) push_bits('b11110, 5);
      else push_bits(('b11111 << 1) | (k - 14), 6);
      if (k >= 2) push_bits(suffix, k - 1);
   endtask

   // wait until all queued bits are sent and every expected value has come out
   task automatic settle();
      while (code_bits.size() != 0 || req_valid || expected_values.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      stim_signed = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int limit;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero and minus one, small classes, sign change mid-word
      idle_pct = 10;
      write_mode(1'b1);
      queue_word(1'b0, 0, 0);
      queue_word(1'b1, 0, 0);
      queue_word(1'b1, 1, 0);
      queue_word(1'b0, 2, 1);
      push_bits('b10, 2);             // negative sign, first prefix bit
      settle();
      write_mode(1'b0);               // must not affect the open codeword
      push_bits('b110, 3);
      queue_word(1'b0, 0, 0);         // unsigned start
      queue_word(1'b0, 1, 0);
      settle();

      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p < 2) write_mode(p[0]);
         else write_mode(1'($urandom_range(1, 0)));
         if (p == RAND_PHASES - 1) idle_pct = 0;
         else begin
            case ($urandom_range(3, 0))
               0: idle_pct = 0;
               1: idle_pct = 8;
               2: idle_pct = 20;
               default: idle_pct = 35;
            endcase
         end
         if (p < 3) begin
            queue_word(1'b0, 15, 'h3FFF);
            queue_word(1'b1, 15, 'h3FFF);
            queue_word(1'b1, 15, 0);
         end
         limit = queued_bits + PHASE_BITS;
         while (queued_bits < limit) begin
            if ($urandom_range(11, 0) == 0)
               push_bits($urandom, $urandom_range(6, 1));
            else
               queue_word(1'($urandom_range(1, 0)), int'($urandom_range(15, 0)),
                          $urandom & 'h3FFF);
         end
         settle();
      end

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/sipd_pkg.sv
hdl/signed_int_prefix_decoder.sv
hdl/sipd_checker.sv
dv/signed_int_prefix_decoder_test.sv
